>>> rtl/core/tcw_pkg.sv
// Package for the text console writer: payload structs, state and op codes,
// register indexes, store sizes and the clamp helpers for columns and rows.
// Depends on nothing; every module of the block imports it.
package tcw_pkg;

   localparam int MAX_COLUMNS = 128;
   localparam int MAX_ROWS    = 32;
   localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;

   localparam int COL_W  = 8;
   localparam int ROW_W  = 6;
   localparam int ATTR_W = 8;
   localparam int CHAR_W = 8;
   localparam int POS_W  = 12;
   localparam int ADDR_W = $clog2(STORE_CELLS);
   localparam int CELL_W = ADDR_W + 1;
   localparam int DATA_W = ATTR_W + CHAR_W;
   localparam int CSR_IDX_W = 2;

   localparam int DIV_STEPS = POS_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'h20;

   localparam logic [COL_W-1:0]  RESET_COLUMNS = 8'd80;
   localparam logic [ROW_W-1:0]  RESET_ROWS    = 6'd25;
   localparam logic [ATTR_W-1:0] RESET_ATTR    = 8'h07;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTR    = 2'd2;

   typedef enum logic [1:0] {
      OP_PUT_CHAR   = 2'd0,
      OP_SET_CURSOR = 2'd1,
      OP_CLEAR      = 2'd2,
      OP_READ_CELL  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIV,
      ST_PLACE,
      ST_READ,
      ST_COPY,
      ST_FILL,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type            op;
      logic [CHAR_W-1:0] char_code;
      logic [POS_W-1:0]  position;
   } req_payload_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_pos;
      logic              scrolled;
      logic [CHAR_W-1:0] cell_char;
      logic [ATTR_W-1:0] cell_attr;
   } rsp_payload_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } store_wr_type;

   function automatic logic [COL_W-1:0] used_columns(input logic [COL_W-1:0] cols);
      logic [COL_W-1:0] res;
      res = cols;
      if (cols == '0) res = COL_W'(1);
      else if (cols > COL_W'(MAX_COLUMNS)) res = COL_W'(MAX_COLUMNS);
      return res;
   endfunction

   function automatic logic [ROW_W-1:0] used_rows(input logic [ROW_W-1:0] rws);
      logic [ROW_W-1:0] res;
      res = rws;
      if (rws == '0) res = ROW_W'(1);
      else if (rws > ROW_W'(MAX_ROWS)) res = ROW_W'(MAX_ROWS);
      return res;
   endfunction

   function automatic logic [CELL_W-1:0] cells_in_use(input logic [COL_W-1:0] cols,
                                                       input logic [ROW_W-1:0] rws);
      logic [COL_W+ROW_W-1:0] prod;
      prod = cols * rws;
      return prod[CELL_W-1:0];
   endfunction

endpackage

>>> rtl/core/tcw_divider.sv
// Iterative remainder unit: one restoring step per cycle over the cursor bits.
// Depends on tcw_pkg for widths and the step count.
module tcw_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [tcw_pkg::POS_W-1:0] dividend,
   input  logic [tcw_pkg::COL_W-1:0] divisor,
   output logic                     done,
   output logic [tcw_pkg::COL_W-1:0] remainder
);
   import tcw_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [POS_W-1:0]     dvd_ff, dvd_in;
   logic [COL_W-1:0]     dsr_ff, dsr_in;
   logic [COL_W-1:0]     rem_ff, rem_in;
   logic [COL_W:0]       trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[POS_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = COL_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[COL_W-1:0];
         end
         dvd_in = {dvd_ff[POS_W-2:0], 1'b0};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/core/tcw_store.sv
// Screen cell store: one write port and one read port with registered data.
// Depends on tcw_pkg for the store size and the write struct.
module tcw_store (
   input  logic                      clock,
   input  tcw_pkg::store_wr_type     wr,
   input  logic [tcw_pkg::ADDR_W-1:0] rd_addr,
   output logic [tcw_pkg::DATA_W-1:0] rd_data
);
   import tcw_pkg::*;

   logic [DATA_W-1:0] cell_mem [STORE_CELLS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         cell_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= cell_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/text_console_writer.sv
// Text console writer top level: sequencer, cursor and registers around the
// cell store and the remainder unit. Depends on tcw_pkg, tcw_store, tcw_divider.
//
// After reset the block sweeps all 4096 store cells to zero, one a cycle, and
// holds req_ready low until the sweep ends. Items are taken one at a time:
// put char, set cursor and read cell each pass through a place or read state
// and then the done state, which registers the result once the output is free
// and makes the block ready for the next item. A newline first waits for the
// remainder unit, which resolves one cursor bit per cycle. Clear and scroll walk
// the single store write port one cell a cycle over the rows*columns cells in
// use, the copy reading one cell ahead of the write it feeds.
module text_console_writer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tcw_pkg::req_payload_type      req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tcw_pkg::rsp_payload_type      rsp_payload,
   input  logic                          csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcw_pkg::COL_W-1:0]     csr_wdata
);
   import tcw_pkg::*;

   state_type         state_ff, state_in;
   logic [POS_W-1:0]  cursor_ff, cursor_in;
   logic [CELL_W-1:0] pos_ff, pos_in;
   logic [CELL_W-1:0] cells_ff, cells_in;
   logic [COL_W-1:0]  cols_ff, cols_in;
   logic [CELL_W-1:0] idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic              scrolled_ff, scrolled_in;
   logic [CHAR_W-1:0] cell_char_ff, cell_char_in;
   logic [ATTR_W-1:0] cell_attr_ff, cell_attr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;
   logic [COL_W-1:0]  columns_ff, columns_in;
   logic [ROW_W-1:0]  rows_ff, rows_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;

   store_wr_type      store_wr;
   logic [ADDR_W-1:0] store_rd_addr;
   logic [DATA_W-1:0] store_rd_data;
   logic              div_start;
   logic              div_done;
   logic [COL_W-1:0]  div_rem;
   logic [COL_W-1:0]  cols_now;
   logic [CELL_W-1:0] copy_count;
   logic [CELL_W-1:0] copy_src;
   logic [DATA_W-1:0] blank;

   tcw_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   tcw_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cursor_ff),
      .divisor   (cols_now),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cursor_ff    <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         columns_ff   <= RESET_COLUMNS;
         rows_ff      <= RESET_ROWS;
         attr_ff      <= RESET_ATTR;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         columns_ff   <= columns_in;
         rows_ff      <= rows_in;
         attr_ff      <= attr_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      cells_ff       <= cells_in;
      cols_ff        <= cols_in;
      pend_addr_ff   <= pend_addr_in;
      scrolled_ff    <= scrolled_in;
      cell_char_ff   <= cell_char_in;
      cell_attr_ff   <= cell_attr_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign cols_now   = used_columns(columns_ff);
   assign copy_count = cells_ff - CELL_W'(cols_ff);
   assign copy_src   = idx_ff + CELL_W'(cols_ff);
   assign blank      = {attr_ff, CODE_SPACE};

   always_comb begin
      state_in       = state_ff;
      cursor_in      = cursor_ff;
      pos_in         = pos_ff;
      cells_in       = cells_ff;
      cols_in        = cols_ff;
      idx_in         = idx_ff;
      pend_in        = pend_ff;
      pend_addr_in   = pend_addr_ff;
      scrolled_in    = scrolled_ff;
      cell_char_in   = cell_char_ff;
      cell_attr_in   = cell_attr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      columns_in     = columns_ff;
      rows_in        = rows_ff;
      attr_in        = attr_ff;
      store_wr       = '0;
      store_rd_addr  = req_payload.position;
      div_start      = 1'b0;
      req_ready      = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_COLUMNS: columns_in = csr_wdata;
            CSR_ROWS:    rows_in    = csr_wdata[ROW_W-1:0];
            CSR_ATTR:    attr_in    = csr_wdata;
            default:     ;
         endcase
      end

      case (state_ff)
         ST_INIT: begin
            store_wr.we   = 1'b1;
            store_wr.addr = idx_ff[ADDR_W-1:0];
            store_wr.data = '0;
            idx_in        = idx_ff + CELL_W'(1);
            if (idx_ff == CELL_W'(STORE_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cells_in     = cells_in_use(cols_now, used_rows(rows_ff));
               cols_in      = cols_now;
               scrolled_in  = 1'b0;
               cell_char_in = '0;
               cell_attr_in = '0;
               idx_in       = '0;
               case (req_payload.op)
                  OP_PUT_CHAR: begin
                     if (req_payload.char_code == CODE_NEWLINE) begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end else begin
                        store_wr.we   = 1'b1;
                        store_wr.addr = cursor_ff;
                        store_wr.data = {attr_ff, req_payload.char_code};
                        pos_in        = {1'b0, cursor_ff} + CELL_W'(1);
                        state_in      = ST_PLACE;
                     end
                  end
                  OP_SET_CURSOR: begin
                     pos_in   = {1'b0, req_payload.position};
                     state_in = ST_PLACE;
                  end
                  OP_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  OP_READ_CELL: begin
                     state_in = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               pos_in   = {1'b0, cursor_ff} - CELL_W'(div_rem) + CELL_W'(cols_ff);
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            if (pos_ff >= cells_ff) begin
               idx_in   = '0;
               pend_in  = 1'b0;
               state_in = ST_COPY;
            end else begin
               cursor_in = pos_ff[POS_W-1:0];
               state_in  = ST_DONE;
            end
         end
         ST_READ: begin
            cell_char_in = store_rd_data[CHAR_W-1:0];
            cell_attr_in = store_rd_data[DATA_W-1:CHAR_W];
            state_in     = ST_DONE;
         end
         ST_COPY: begin
            if (pend_ff) begin
               store_wr.we   = 1'b1;
               store_wr.addr = pend_addr_ff;
               store_wr.data = store_rd_data;
            end
            if (idx_ff != copy_count) begin
               store_rd_addr = copy_src[ADDR_W-1:0];
               pend_in       = 1'b1;
               pend_addr_in  = idx_ff[ADDR_W-1:0];
               idx_in        = idx_ff + CELL_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            store_wr.we   = 1'b1;
            store_wr.addr = idx_ff[ADDR_W-1:0];
            store_wr.data = blank;
            idx_in        = idx_ff + CELL_W'(1);
            if (idx_ff == cells_ff - CELL_W'(1)) begin
               cursor_in   = copy_count[POS_W-1:0];
               scrolled_in = 1'b1;
               state_in    = ST_DONE;
            end
         end
         ST_CLEAR: begin
            store_wr.we   = 1'b1;
            store_wr.addr = idx_ff[ADDR_W-1:0];
            store_wr.data = blank;
            idx_in        = idx_ff + CELL_W'(1);
            if (idx_ff == cells_ff - CELL_W'(1)) begin
               cursor_in = '0;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.cursor_pos = cursor_ff;
               rsp_payload_in.scrolled   = scrolled_ff;
               rsp_payload_in.cell_char  = cell_char_ff;
               rsp_payload_in.cell_attr  = cell_attr_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> rtl/core/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg for the payload structs.
module tcw_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input tcw_pkg::req_payload_type      req_payload,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input tcw_pkg::rsp_payload_type      rsp_payload,
   input logic                          csr_we,
   input logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [tcw_pkg::COL_W-1:0]     csr_wdata
);
   import tcw_pkg::*;

   logic unused_inputs;
   assign unused_inputs = ^{req_payload, csr_we, csr_index, csr_wdata};

   // A stalled result keeps its valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result valid dropped while stalled");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("result payload changed while stalled");

   // After taking an item the block drops req_ready.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block ready right after taking an item");

   // Only a cell read returns cell contents, and a read never scrolls.
   a_read_no_scroll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.cell_char != '0 || rsp_payload.cell_attr != '0)
      |-> !rsp_payload.scrolled)
      else $error("cell contents returned with a scroll");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

>>> sim/tcw_screen_checker.sv
// Checker for the text console writer: keeps its own screen cells, cursor and
// settings, predicts the result of every item and compares it with the block.
// Depends on tcw_pkg; instantiated beside the block by tb.
module tcw_screen_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  tcw_pkg::req_payload_type      req_payload,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  tcw_pkg::rsp_payload_type      rsp_payload,
   input  logic                          csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcw_pkg::COL_W-1:0]     csr_wdata,
   output int                            fail_count,
   output int                            pending_count
);
   import tcw_pkg::*;

   logic [DATA_W-1:0] screen_mem [STORE_CELLS];
   logic [POS_W-1:0]  cursor;
   logic [COL_W-1:0]  columns_reg;
   logic [ROW_W-1:0]  rows_reg;
   logic [ATTR_W-1:0] attr_reg;
   rsp_payload_type   screen_results_q [$];
   int                errors = 0;

   function automatic int used_cols();
      if (columns_reg == '0) return 1;
      if (int'(columns_reg) > MAX_COLUMNS) return MAX_COLUMNS;
      return int'(columns_reg);
   endfunction

   function automatic int used_row_count();
      if (rows_reg == '0) return 1;
      if (int'(rows_reg) > MAX_ROWS) return MAX_ROWS;
      return int'(rows_reg);
   endfunction

   // The screen moves up by a single row, however far past the end the cursor lands.
   function automatic logic land_cursor(input int target);
      int   cols;
      int   area;
      logic rolled;
      cols = used_cols();
      area = cols * used_row_count();
      rolled = 1'b0;
      if (target >= area) begin
         for (int i = 0; i + cols < area; i++) screen_mem[i] = screen_mem[i + cols];
         for (int i = area - cols; i < area; i++) screen_mem[i] = {attr_reg, CODE_SPACE};
         target = area - cols;
         rolled = 1'b1;
      end
      cursor = POS_W'(target);
      return rolled;
   endfunction

   function automatic rsp_payload_type apply_console_op(input req_payload_type item);
      rsp_payload_type res;
      int              cols;
      res = '0;
      cols = used_cols();
      case (item.op)
         OP_PUT_CHAR: begin
            if (item.char_code == CODE_NEWLINE) begin
               res.scrolled = land_cursor((int'(cursor) / cols + 1) * cols);
            end else begin
               screen_mem[cursor] = {attr_reg, item.char_code};
               res.scrolled = land_cursor(int'(cursor) + 1);
            end
         end
         OP_SET_CURSOR: begin
            res.scrolled = land_cursor(int'(item.position));
         end
         OP_CLEAR: begin
            for (int i = 0; i < cols * used_row_count(); i++) begin
               screen_mem[i] = {attr_reg, CODE_SPACE};
            end
            res.scrolled = land_cursor(0);
         end
         OP_READ_CELL: begin
            res.cell_char = screen_mem[item.position][CHAR_W-1:0];
            res.cell_attr = screen_mem[item.position][DATA_W-1:CHAR_W];
         end
         default: ;
      endcase
      res.cursor_pos = cursor;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         for (int i = 0; i < STORE_CELLS; i++) screen_mem[i] = '0;
         cursor = '0;
         columns_reg = RESET_COLUMNS;
         rows_reg = RESET_ROWS;
         attr_reg = RESET_ATTR;
         screen_results_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_COLUMNS: columns_reg = csr_wdata;
               CSR_ROWS:    rows_reg = csr_wdata[ROW_W-1:0];
               CSR_ATTR:    attr_reg = csr_wdata;
               default:     ;
            endcase
         end
         if (req_valid && req_ready) begin
            screen_results_q.push_back(apply_console_op(req_payload));
         end
         if (rsp_valid && rsp_ready) begin
            if (screen_results_q.size() == 0) begin
               $display("%0t: result with none expected: cursor_pos %0d scrolled %0b char %h attr %h",
                        $time, rsp_payload.cursor_pos, rsp_payload.scrolled,
                        rsp_payload.cell_char, rsp_payload.cell_attr);
               errors++;
            end else begin
               want = screen_results_q.pop_front();
               if (rsp_payload.cursor_pos !== want.cursor_pos) begin
                  $display("%0t: cursor_pos expected %0d actual %0d",
                           $time, want.cursor_pos, rsp_payload.cursor_pos);
                  errors++;
               end
               if (rsp_payload.scrolled !== want.scrolled) begin
                  $display("%0t: scrolled expected %0b actual %0b",
                           $time, want.scrolled, rsp_payload.scrolled);
                  errors++;
               end
               if (rsp_payload.cell_char !== want.cell_char) begin
                  $display("%0t: cell_char expected %h actual %h",
                           $time, want.cell_char, rsp_payload.cell_char);
                  errors++;
               end
               if (rsp_payload.cell_attr !== want.cell_attr) begin
                  $display("%0t: cell_attr expected %h actual %h",
                           $time, want.cell_attr, rsp_payload.cell_attr);
                  errors++;
               end
            end
         end
      end
      pending_count <= screen_results_q.size();
      fail_count <= errors;
   end

endmodule

>>> sim/tb.sv
// Top of the text console writer testbench: clock, reset, settings writes and item
// traffic with random stalls on both sides; the verdict comes from the failure and
// pending counts of tcw_screen_checker. Depends on tcw_pkg, text_console_writer.
module tb;
   import tcw_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_AFTER     = 60;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_payload_type      req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_payload_type      rsp_payload;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COL_W-1:0]     csr_wdata;
   int                   fail_count;
   int                   pending_count;
   int                   results_seen = 0;
   int                   quiet_cycles = 0;
   logic                 calm = 1'b0;
   logic                 long_hold_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_console_writer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   tcw_screen_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) results_seen <= results_seen + 1;
   end

   task automatic send_item(input op_type kind, input logic [CHAR_W-1:0] code,
                            input logic [POS_W-1:0] pos);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{op: kind, char_code: code, position: pos};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_settings(input logic [COL_W-1:0] cols, input logic [COL_W-1:0] rws,
                                 input logic [ATTR_W-1:0] attr);
      csr_we <= 1'b1;
      csr_index <= CSR_COLUMNS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= CSR_ROWS;
      csr_wdata <= rws;
      @(posedge clock);
      csr_index <= CSR_ATTR;
      csr_wdata <= attr;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= COL_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input logic [COL_W-1:0] cols, input logic [COL_W-1:0] rws,
                            input logic [ATTR_W-1:0] attr, input int count,
                            input logic quiet);
      int col_n;
      int row_n;
      int area;
      int pick;
      drain();
      write_settings(cols, rws, attr);
      calm = quiet;
      col_n = (cols == '0) ? 1 : (int'(cols) > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols);
      row_n = (rws[ROW_W-1:0] == '0) ? 1 :
              (int'(rws[ROW_W-1:0]) > MAX_ROWS) ? MAX_ROWS : int'(rws[ROW_W-1:0]);
      area = col_n * row_n;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            send_item(OP_PUT_CHAR,
                      ($urandom_range(0, 9) == 0) ? CODE_NEWLINE : CHAR_W'($urandom),
                      POS_W'($urandom));
         end else if (pick < 65) begin
            send_item(OP_SET_CURSOR, CHAR_W'($urandom),
                      ($urandom_range(0, 4) == 0) ? POS_W'($urandom) :
                                                    POS_W'($urandom_range(0, area - 1)));
         end else if (pick < 70) begin
            send_item(OP_CLEAR, CHAR_W'($urandom), POS_W'($urandom));
         end else begin
            send_item(OP_READ_CELL, CHAR_W'($urandom),
                      ($urandom_range(0, 5) == 0) ? POS_W'($urandom) :
                                                    POS_W'($urandom_range(0, area - 1)));
         end
      end
   endtask

   // The receiver holds off once for a long stretch so that the block backs up.
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("text_console_writer test failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = CSR_COLUMNS;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_READ_CELL, 8'h00, 12'd0);
      send_item(OP_PUT_CHAR, 8'h41, 12'd0);
      send_item(OP_PUT_CHAR, 8'h00, 12'hFFF);
      send_item(OP_PUT_CHAR, 8'hFF, 12'd0);
      send_item(OP_PUT_CHAR, CODE_NEWLINE, 12'd0);
      send_item(OP_READ_CELL, 8'hFF, 12'd1);
      send_item(OP_READ_CELL, 8'h00, 12'd2);
      send_item(OP_SET_CURSOR, 8'h00, 12'd1999);
      send_item(OP_PUT_CHAR, 8'h5A, 12'd0);
      send_item(OP_READ_CELL, 8'h00, 12'd1919);
      send_item(OP_SET_CURSOR, 8'h00, 12'd1950);
      send_item(OP_PUT_CHAR, CODE_NEWLINE, 12'd0);
      send_item(OP_SET_CURSOR, 8'h00, 12'd2000);
      send_item(OP_SET_CURSOR, 8'h00, 12'hFFF);
      send_item(OP_READ_CELL, 8'h00, 12'hFFF);
      send_item(OP_READ_CELL, 8'h00, 12'd80);
      send_item(OP_CLEAR, 8'h00, 12'd0);
      send_item(OP_READ_CELL, 8'h00, 12'd0);
      send_item(OP_READ_CELL, 8'h00, 12'd1999);
      send_item(OP_SET_CURSOR, 8'h00, 12'h555);
      send_item(OP_PUT_CHAR, 8'hAA, 12'h555);
      send_item(OP_PUT_CHAR, 8'h55, 12'hAAA);
      send_item(OP_READ_CELL, 8'h00, 12'h555);
      send_item(OP_SET_CURSOR, 8'h00, 12'hAAA);
      send_item(OP_SET_CURSOR, 8'h00, 12'd0);

      run_phase(8'd8, 8'd4, 8'h1E, 70, $urandom_range(0, 3) == 0);
      run_phase(8'd1, 8'hC1, 8'hFF, 50, $urandom_range(0, 3) == 0);
      run_phase(8'd0, 8'd0, 8'h00, 50, $urandom_range(0, 3) == 0);
      run_phase(8'd16, 8'd6, 8'h70, 80, $urandom_range(0, 3) == 0);
      run_phase(8'd255, 8'd1, 8'h4F, 50, $urandom_range(0, 3) == 0);
      run_phase(8'd3, 8'd63, 8'hA5, 60, $urandom_range(0, 3) == 0);
      run_phase(8'd128, 8'd32, 8'h5A, 12, $urandom_range(0, 3) == 0);
      run_phase(8'd12, 8'd5, 8'h0F, 80, $urandom_range(0, 3) == 0);
      run_phase(8'd5, 8'd9, 8'h3C, 70, $urandom_range(0, 3) == 0);
      run_phase(8'd40, 8'd2, 8'hC3, 70, $urandom_range(0, 3) == 0);
      run_phase(8'd7, 8'd3, 8'h81, 90, 1'b1);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("text_console_writer test passed");
      end else begin
         $display("text_console_writer test failed");
      end
      $finish;
   end

endmodule
